### design/dual_thrust_breakout_signal_assert.svh
// Assertion helpers for the breakout signal block.
// Both expect aclk and aresetn in the scope where they are used.
`ifndef DUAL_THRUST_BREAKOUT_SIGNAL_ASSERT_SVH
`define DUAL_THRUST_BREAKOUT_SIGNAL_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DTB_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("dtb: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define DTB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("dtb: next-cycle check failed");

`endif

### design/dtb_pkg.sv
package dtb_pkg;

    localparam int HISTORY_DEPTH_DEF = 64;
    localparam int PRICE_BITS_DEF    = 31;

    localparam int GAIN_W     = 16;
    localparam int GAIN_FRAC  = 12;
    localparam int WDAYS_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int BAND_W     = 36;
    localparam int SIG_W      = 3;
    localparam int TGT_W      = 8;
    localparam int POS_W      = 2;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_DAYS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_GAIN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STOCK_MODE  = 2'd3;

    localparam logic [WDAYS_W-1:0] WINDOW_DAYS_RST = 7'd21;
    localparam logic [GAIN_W-1:0]  UPPER_GAIN_RST  = 16'd2048;
    localparam logic [GAIN_W-1:0]  LOWER_GAIN_RST  = 16'd2048;
    localparam logic               STOCK_MODE_RST  = 1'b0;

    localparam logic signed [BAND_W-1:0] BAND_MAX = 36'sh7_FFFF_FFFF;
    localparam logic signed [BAND_W-1:0] BAND_MIN = -36'sh8_0000_0000;

    localparam logic signed [TGT_W-1:0] UNIT_STOCK = 8'sd100;
    localparam logic signed [TGT_W-1:0] UNIT_PLAIN = 8'sd1;

    localparam logic [POS_W-1:0] POS_FLAT = 2'b00;
    localparam logic [POS_W-1:0] POS_LONG = 2'b01;

    typedef enum logic [SIG_W-1:0] {
        SIG_NONE        = 3'd0,
        SIG_ENTER_LONG  = 3'd1,
        SIG_ENTER_SHORT = 3'd2,
        SIG_EXIT_LONG   = 3'd3,
        SIG_EXIT_SHORT  = 3'd4
    } signal_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RANGE,
        ST_MUL_UP,
        ST_MUL_LO,
        ST_BAND_LO,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic fold;
        logic first;
        logic calc;
        logic zero;
    } scan_ctrl_t;

    typedef struct packed {
        logic mul_go;
        logic mul_lower;
        logic upd_upper;
        logic upd_lower;
    } band_ctrl_t;

endpackage

### design/dtb_ram.sv
module dtb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/dtb_extremes.sv
module dtb_extremes
    import dtb_pkg::*;
#(
    parameter int PRICE_BITS = PRICE_BITS_DEF
) (
    input  logic                         aclk,
    input  scan_ctrl_t                   ctrl,
    input  logic [PRICE_BITS-1:0]        rd_high,
    input  logic [PRICE_BITS-1:0]        rd_low,
    input  logic [PRICE_BITS-1:0]        rd_close,
    output logic signed [PRICE_BITS:0]   range
);

    logic [PRICE_BITS-1:0] hh_reg, ll_reg, hc_reg, lc_reg;
    logic [PRICE_BITS-1:0] hh_next, ll_next, hc_next, lc_next;
    logic signed [PRICE_BITS:0] span_a, span_b;
    logic signed [PRICE_BITS:0] range_reg, range_next;

    // fold one history entry into the running extremes
    always_comb begin
        hh_next = (ctrl.first || rd_high > hh_reg)  ? rd_high  : hh_reg;
        ll_next = (ctrl.first || rd_low < ll_reg)   ? rd_low   : ll_reg;
        hc_next = (ctrl.first || rd_close > hc_reg) ? rd_close : hc_reg;
        lc_next = (ctrl.first || rd_close < lc_reg) ? rd_close : lc_reg;
    end

    always_comb begin
        span_a = $signed({1'b0, hh_reg}) - $signed({1'b0, lc_reg});
        span_b = $signed({1'b0, hc_reg}) - $signed({1'b0, ll_reg});
        if (ctrl.zero) begin
            range_next = '0;
        end else begin
            range_next = (span_a > span_b) ? span_a : span_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.fold) begin
            hh_reg <= hh_next;
            ll_reg <= ll_next;
            hc_reg <= hc_next;
            lc_reg <= lc_next;
        end
        if (ctrl.calc) begin
            range_reg <= range_next;
        end
    end

    assign range = range_reg;

endmodule

### design/dtb_band.sv
module dtb_band
    import dtb_pkg::*;
#(
    parameter int PRICE_BITS = PRICE_BITS_DEF
) (
    input  logic                       aclk,
    input  band_ctrl_t                 ctrl,
    input  logic [GAIN_W-1:0]          upper_gain,
    input  logic [GAIN_W-1:0]          lower_gain,
    input  logic [PRICE_BITS-1:0]      open,
    input  logic signed [PRICE_BITS:0] range,
    output logic signed [BAND_W-1:0]   upper,
    output logic signed [BAND_W-1:0]   lower
);

    localparam int RW        = PRICE_BITS + 1;
    localparam int PW        = RW + GAIN_W + 1;
    localparam int CW        = PW - GAIN_FRAC;
    localparam int EXTW      = (PRICE_BITS + 8 > BAND_W + 1) ? PRICE_BITS + 8 : BAND_W + 1;
    localparam int ROUND_ADD = (1 << GAIN_FRAC) - 1;
    localparam logic signed [EXTW-1:0] BMAX_EXT = EXTW'(BAND_MAX);
    localparam logic signed [EXTW-1:0] BMIN_EXT = EXTW'(BAND_MIN);

    logic signed [PW-1:0]     prod_reg, prod_next, rounded;
    logic signed [CW-1:0]     ceil_v;
    logic signed [EXTW-1:0]   open_ext, c_ext, addend, sum;
    logic signed [BAND_W-1:0] band_sat;
    logic signed [BAND_W-1:0] upper_reg, lower_reg;

    // one multiplier shared by both gains
    assign prod_next = $signed({1'b0, (ctrl.mul_lower ? lower_gain : upper_gain)}) * range;

    // ceil(k*range / 4096): add fraction mask, arithmetic shift
    always_comb begin
        rounded  = (prod_reg + PW'(ROUND_ADD)) >>> GAIN_FRAC;
        ceil_v   = rounded[CW-1:0];
        c_ext    = EXTW'(ceil_v);
        open_ext = EXTW'({1'b0, open});
        addend   = ctrl.upd_lower ? -c_ext : c_ext;
        sum      = open_ext + addend;
        if (sum > BMAX_EXT) begin
            band_sat = BAND_MAX;
        end else if (sum < BMIN_EXT) begin
            band_sat = BAND_MIN;
        end else begin
            band_sat = sum[BAND_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul_go) begin
            prod_reg <= prod_next;
        end
        if (ctrl.upd_upper) begin
            upper_reg <= band_sat;
        end
        if (ctrl.upd_lower) begin
            lower_reg <= band_sat;
        end
    end

    assign upper = upper_reg;
    assign lower = lower_reg;

endmodule

### design/dual_thrust_breakout_signal.sv
// Channel   | Direction | Handshake          | Payload
// s_ (bar)  | in        | s_valid / s_ready  | open, high, low, close, complete, position_sign
// m_ (sig)  | out       | m_valid / m_ready  | signal, target_position, bands, window_ready
// cfg_      | in        | cfg_wr_en          | cfg_index, cfg_wdata (write only)
//
// When the window is full, each bar first scans the newest n history entries,
// n = min(max(window_days, 2) - 1, HISTORY_DEPTH); otherwise the scan is skipped.
// The scan length is set by the history memory's single read port: one entry a cycle.
// Reset clears the fill count and write slot; history memory needs no clearing pass.
// A waiting result sits in the output register while the next bar is accepted;
// the block stalls only in its final step when that register is still occupied.
`include "dual_thrust_breakout_signal_assert.svh"

module dual_thrust_breakout_signal
    import dtb_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int PRICE_BITS    = PRICE_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_wdata,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [PRICE_BITS-1:0]       s_bar_open,
    input  logic [PRICE_BITS-1:0]       s_bar_high,
    input  logic [PRICE_BITS-1:0]       s_bar_low,
    input  logic [PRICE_BITS-1:0]       s_bar_close,
    input  logic                        s_bar_complete,
    input  logic signed [POS_W-1:0]     s_position_sign,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [SIG_W-1:0]            m_signal,
    output logic signed [TGT_W-1:0]     m_target_position,
    output logic signed [BAND_W-1:0]    m_upper_band,
    output logic signed [BAND_W-1:0]    m_lower_band,
    output logic                        m_window_ready
);

    localparam int AW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int NCW   = (CNT_W > WDAYS_W) ? CNT_W : WDAYS_W;
    localparam int CMPW  = (PRICE_BITS + 1 > BAND_W) ? PRICE_BITS + 1 : BAND_W;
    localparam int HW    = 3 * PRICE_BITS;

    // configuration
    logic [WDAYS_W-1:0] wdays_reg;
    logic [GAIN_W-1:0]  upper_gain_reg, lower_gain_reg;
    logic               stock_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wdays_reg      <= WINDOW_DAYS_RST;
            upper_gain_reg <= UPPER_GAIN_RST;
            lower_gain_reg <= LOWER_GAIN_RST;
            stock_reg      <= STOCK_MODE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_WINDOW_DAYS: wdays_reg      <= cfg_wdata[WDAYS_W-1:0];
                REG_UPPER_GAIN:  upper_gain_reg <= cfg_wdata[GAIN_W-1:0];
                REG_LOWER_GAIN:  lower_gain_reg <= cfg_wdata[GAIN_W-1:0];
                REG_STOCK_MODE:  stock_reg      <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // window length actually used
    logic [WDAYS_W-1:0] n_raw;
    logic [CNT_W-1:0]   n_now;
    logic               ready_now;
    logic [CNT_W-1:0]   fill_reg, fill_next;

    always_comb begin
        n_raw     = (wdays_reg < WDAYS_W'(2)) ? WDAYS_W'(1) : wdays_reg - 1'b1;
        n_now     = (NCW'(n_raw) > NCW'(HISTORY_DEPTH)) ? CNT_W'(HISTORY_DEPTH)
                                                         : CNT_W'(n_raw);
        ready_now = (fill_reg >= n_now);
    end

    // state
    state_t state_reg, state_next;

    logic [AW-1:0]    slot_reg, slot_next;
    logic [AW-1:0]    raddr_reg, raddr_next;
    logic [CNT_W-1:0] issue_cnt_reg, issue_cnt_next;
    logic [CNT_W-1:0] recv_cnt_reg, recv_cnt_next;
    logic             rd_valid_reg, rd_valid_next;
    logic             m_valid_reg, m_valid_next;

    // captured transaction
    logic [PRICE_BITS-1:0] open_reg, high_reg, low_reg, close_reg;
    logic                  complete_reg;
    logic [POS_W-1:0]      pos_reg;
    logic                  win_ready_reg;
    logic [CNT_W-1:0]      n_reg;

    // control
    logic       accept, issue, scan_done, out_free, out_load, ram_we;
    scan_ctrl_t scan_ctrl;
    band_ctrl_t band_ctrl;

    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign scan_done = rd_valid_reg && (recv_cnt_reg == n_reg - 1'b1);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ready_now ? ST_SCAN : ST_RANGE;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_RANGE;
                end
            end
            ST_RANGE:   state_next = ST_MUL_UP;
            ST_MUL_UP:  state_next = ST_MUL_LO;
            ST_MUL_LO:  state_next = ST_BAND_LO;
            ST_BAND_LO: state_next = ST_DECIDE;
            ST_DECIDE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        issue     = 1'b0;
        ram_we    = 1'b0;
        out_load  = 1'b0;
        scan_ctrl = '0;
        band_ctrl = '0;
        unique case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_SCAN: begin
                issue           = (issue_cnt_reg < n_reg);
                scan_ctrl.fold  = rd_valid_reg;
                scan_ctrl.first = (recv_cnt_reg == '0);
            end
            ST_RANGE: begin
                scan_ctrl.calc = 1'b1;
                scan_ctrl.zero = !win_ready_reg;
            end
            ST_MUL_UP: band_ctrl.mul_go = 1'b1;
            ST_MUL_LO: begin
                band_ctrl.mul_go    = 1'b1;
                band_ctrl.mul_lower = 1'b1;
                band_ctrl.upd_upper = 1'b1;
            end
            ST_BAND_LO: begin
                band_ctrl.upd_lower = 1'b1;
                ram_we              = complete_reg;
            end
            ST_DECIDE: out_load = out_free;
            default: ;
        endcase
    end

    // counters and pointers
    always_comb begin
        fill_next      = fill_reg;
        slot_next      = slot_reg;
        raddr_next     = raddr_reg;
        issue_cnt_next = issue_cnt_reg;
        recv_cnt_next  = recv_cnt_reg;
        rd_valid_next  = issue;
        if (accept) begin
            // newest entry sits just behind the write slot
            raddr_next     = (slot_reg == '0) ? AW'(HISTORY_DEPTH - 1) : slot_reg - 1'b1;
            issue_cnt_next = '0;
            recv_cnt_next  = '0;
        end
        if (issue) begin
            raddr_next     = (raddr_reg == '0) ? AW'(HISTORY_DEPTH - 1) : raddr_reg - 1'b1;
            issue_cnt_next = issue_cnt_reg + 1'b1;
        end
        if (scan_ctrl.fold) begin
            recv_cnt_next = recv_cnt_reg + 1'b1;
        end
        if (ram_we) begin
            slot_next = (slot_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
            if (fill_reg < CNT_W'(HISTORY_DEPTH)) begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            slot_reg      <= '0;
            raddr_reg     <= '0;
            issue_cnt_reg <= '0;
            recv_cnt_reg  <= '0;
            rd_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            slot_reg      <= slot_next;
            raddr_reg     <= raddr_next;
            issue_cnt_reg <= issue_cnt_next;
            recv_cnt_reg  <= recv_cnt_next;
            rd_valid_reg  <= rd_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            open_reg      <= s_bar_open;
            high_reg      <= s_bar_high;
            low_reg       <= s_bar_low;
            close_reg     <= s_bar_close;
            complete_reg  <= s_bar_complete;
            pos_reg       <= s_position_sign;
            win_ready_reg <= ready_now;
            n_reg         <= n_now;
        end
    end

    // history memory: {high, low, close}
    logic [HW-1:0] hist_rdata;

    dtb_ram #(
        .WIDTH (HW),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata ({high_reg, low_reg, close_reg}),
        .raddr (raddr_reg),
        .rdata (hist_rdata)
    );

    logic signed [PRICE_BITS:0] range_val;

    dtb_extremes #(
        .PRICE_BITS (PRICE_BITS)
    ) u_extremes (
        .aclk     (aclk),
        .ctrl     (scan_ctrl),
        .rd_high  (hist_rdata[HW-1 -: PRICE_BITS]),
        .rd_low   (hist_rdata[2*PRICE_BITS-1 -: PRICE_BITS]),
        .rd_close (hist_rdata[PRICE_BITS-1:0]),
        .range    (range_val)
    );

    logic signed [BAND_W-1:0] upper_val, lower_val;

    dtb_band #(
        .PRICE_BITS (PRICE_BITS)
    ) u_band (
        .aclk       (aclk),
        .ctrl       (band_ctrl),
        .upper_gain (upper_gain_reg),
        .lower_gain (lower_gain_reg),
        .open       (open_reg),
        .range      (range_val),
        .upper      (upper_val),
        .lower      (lower_val)
    );

    // trade decision
    logic signed [CMPW-1:0]  high_ext, low_ext, upper_ext, lower_ext;
    logic                    up_hit, lo_hit;
    logic signed [TGT_W-1:0] unit, tgt;
    signal_t                 sig;

    always_comb begin
        high_ext  = CMPW'({1'b0, high_reg});
        low_ext   = CMPW'({1'b0, low_reg});
        upper_ext = CMPW'(upper_val);
        lower_ext = CMPW'(lower_val);
        up_hit    = (high_ext >= upper_ext);
        lo_hit    = (low_ext <= lower_ext);
        unit      = stock_reg ? UNIT_STOCK : UNIT_PLAIN;
        sig       = SIG_NONE;
        tgt       = '0;
        if (win_ready_reg) begin
            case (pos_reg)
                POS_FLAT: begin
                    if (up_hit) begin
                        sig = SIG_ENTER_LONG;
                        tgt = unit;
                    end else if (lo_hit && !stock_reg) begin
                        sig = SIG_ENTER_SHORT;
                        tgt = -unit;
                    end
                end
                POS_LONG: begin
                    if (lo_hit) begin
                        sig = SIG_EXIT_LONG;
                    end
                end
                default: begin
                    // both short codes
                    if (up_hit && !stock_reg) begin
                        sig = SIG_EXIT_SHORT;
                    end
                end
            endcase
        end
    end

    // output register
    logic [SIG_W-1:0]         sig_reg;
    logic signed [TGT_W-1:0]  tgt_reg;
    logic signed [BAND_W-1:0] upper_out_reg, lower_out_reg;
    logic                     ready_out_reg;

    always_ff @(posedge aclk) begin
        if (out_load) begin
            sig_reg       <= sig;
            tgt_reg       <= tgt;
            upper_out_reg <= upper_val;
            lower_out_reg <= lower_val;
            ready_out_reg <= win_ready_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_signal          = sig_reg;
    assign m_target_position = tgt_reg;
    assign m_upper_band      = upper_out_reg;
    assign m_lower_band      = lower_out_reg;
    assign m_window_ready    = ready_out_reg;

    `DTB_ASSERT_NEXT(a_accept_leaves_idle, accept, state_reg != ST_IDLE)
    `DTB_ASSERT_SAME(a_hist_write_after_scan, ram_we, state_reg == ST_BAND_LO)
    `DTB_ASSERT_SAME(a_scan_order, 1'b1, recv_cnt_reg <= issue_cnt_reg)
    `DTB_ASSERT_SAME(a_fill_bound, 1'b1, fill_reg <= CNT_W'(HISTORY_DEPTH))
    `DTB_ASSERT_SAME(a_no_signal_unready, m_valid && !m_window_ready,
                     m_signal == SIG_NONE && m_target_position == '0)

endmodule

### test/testbench.sv
module testbench;
    import dtb_pkg::*;

    localparam int PW = PRICE_BITS_DEF;
    localparam int DEPTH = HISTORY_DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 100;
    localparam logic [PW-1:0] PX_MAX = '1;
    localparam logic [POS_W-1:0] POS_SHORT = 2'b11;
    // -2 is an illegal position code that the block treats as short
    localparam logic [POS_W-1:0] POS_ODD = 2'b10;

    typedef struct {
        logic [PW-1:0]    open_px;
        logic [PW-1:0]    high_px;
        logic [PW-1:0]    low_px;
        logic [PW-1:0]    close_px;
        logic             complete;
        logic [POS_W-1:0] pos;
    } bar_t;

    typedef struct {
        signal_t                  sig;
        logic signed [TGT_W-1:0]  target;
        logic signed [BAND_W-1:0] upper;
        logic signed [BAND_W-1:0] lower;
        logic                     ready;
    } breakout_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_wdata = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [PW-1:0]            s_bar_open = '0;
    logic [PW-1:0]            s_bar_high = '0;
    logic [PW-1:0]            s_bar_low = '0;
    logic [PW-1:0]            s_bar_close = '0;
    logic                     s_bar_complete = 1'b0;
    logic signed [POS_W-1:0]  s_position_sign = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [SIG_W-1:0]         m_signal;
    logic signed [TGT_W-1:0]  m_target_position;
    logic signed [BAND_W-1:0] m_upper_band;
    logic signed [BAND_W-1:0] m_lower_band;
    logic                     m_window_ready;

    // Shadow copy of the block's history and registers
    logic [PW-1:0]      hist_high [DEPTH];
    logic [PW-1:0]      hist_low [DEPTH];
    logic [PW-1:0]      hist_close [DEPTH];
    int unsigned        hist_fill = 0;
    int unsigned        hist_slot = 0;
    logic [WDAYS_W-1:0] cfg_days = WINDOW_DAYS_RST;
    logic [GAIN_W-1:0]  cfg_up = UPPER_GAIN_RST;
    logic [GAIN_W-1:0]  cfg_lo = LOWER_GAIN_RST;
    logic               cfg_stock = STOCK_MODE_RST;

    breakout_t expected_signals [$];
    int        errors = 0;
    int        valid_gap_pct = 0;
    int        ready_stall_pct = 0;
    int        hold_left = 0;
    int        quiet_cycles = 0;
    longint    price_level = 1000000;

    dual_thrust_breakout_signal uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_bar_open        (s_bar_open),
        .s_bar_high        (s_bar_high),
        .s_bar_low         (s_bar_low),
        .s_bar_close       (s_bar_close),
        .s_bar_complete    (s_bar_complete),
        .s_position_sign   (s_position_sign),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_signal          (m_signal),
        .m_target_position (m_target_position),
        .m_upper_band      (m_upper_band),
        .m_lower_band      (m_lower_band),
        .m_window_ready    (m_window_ready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ceil(k * v / 4096) without losing the fraction
    function automatic longint ceil_scaled(input longint k, input longint v);
        longint q, r;
        if (v >= 0) begin
            q = v / 4096;
        end else begin
            q = -((-v + 4095) / 4096);
        end
        r = v - q * 4096;
        return k * q + (k * r + 4095) / 4096;
    endfunction

    function automatic longint band_clamp(input longint v);
        if (v > BAND_MAX) begin
            return BAND_MAX;
        end
        if (v < BAND_MIN) begin
            return BAND_MIN;
        end
        return v;
    endfunction

    function automatic breakout_t predict_breakout(input bar_t b);
        breakout_t               r;
        int unsigned             span_len, slot, i;
        longint                  hh, ll, hc, lc, h, l, c, spread, up_band, lo_band;
        longint                  open_px, hi_px, lo_px;
        logic signed [TGT_W-1:0] unit;
        open_px = b.open_px;
        hi_px = b.high_px;
        lo_px = b.low_px;
        unit = cfg_stock ? UNIT_STOCK : UNIT_PLAIN;
        r.sig = SIG_NONE;
        r.target = '0;
        r.upper = open_px;
        r.lower = open_px;
        span_len = (cfg_days < 2) ? 2 : cfg_days;
        span_len = span_len - 1;
        if (span_len > DEPTH) begin
            span_len = DEPTH;
        end
        r.ready = (hist_fill >= span_len);
        if (r.ready) begin
            hh = 0;
            ll = 0;
            hc = 0;
            lc = 0;
            for (i = 0; i < span_len; i++) begin
                slot = (hist_slot + DEPTH - 1 - i) % DEPTH;
                h = hist_high[slot];
                l = hist_low[slot];
                c = hist_close[slot];
                if (i == 0 || h > hh) hh = h;
                if (i == 0 || l < ll) ll = l;
                if (i == 0 || c > hc) hc = c;
                if (i == 0 || c < lc) lc = c;
            end
            spread = (hh - lc > hc - ll) ? hh - lc : hc - ll;
            up_band = band_clamp(open_px + ceil_scaled(longint'(cfg_up), spread));
            lo_band = band_clamp(open_px - ceil_scaled(longint'(cfg_lo), spread));
            r.upper = up_band;
            r.lower = lo_band;
            if (b.pos == POS_FLAT) begin
                if (hi_px >= up_band) begin
                    r.sig = SIG_ENTER_LONG;
                    r.target = unit;
                end else if (lo_px <= lo_band && !cfg_stock) begin
                    r.sig = SIG_ENTER_SHORT;
                    r.target = -unit;
                end
            end else if (b.pos == POS_LONG) begin
                if (lo_px <= lo_band) begin
                    r.sig = SIG_EXIT_LONG;
                end
            end else if (hi_px >= up_band && !cfg_stock) begin
                r.sig = SIG_EXIT_SHORT;
            end
        end
        // the bar joins history only after its own evaluation
        if (b.complete) begin
            hist_high[hist_slot] = b.high_px;
            hist_low[hist_slot] = b.low_px;
            hist_close[hist_slot] = b.close_px;
            hist_slot = (hist_slot + 1) % DEPTH;
            if (hist_fill < DEPTH) begin
                hist_fill++;
            end
        end
        return r;
    endfunction

    function automatic bar_t make_bar(input longint o, h, l, c, input logic comp,
                                      input logic [POS_W-1:0] pos);
        bar_t b;
        b.open_px = o;
        b.high_px = h;
        b.low_px = l;
        b.close_px = c;
        b.complete = comp;
        b.pos = pos;
        return b;
    endfunction

    function automatic longint clamp_px(input longint v);
        if (v < 0) begin
            return 0;
        end
        if (v > longint'(PX_MAX)) begin
            return longint'(PX_MAX);
        end
        return v;
    endfunction

    function automatic longint jitter(input int bits);
        return longint'($urandom_range(0, 2 << bits)) - (longint'(1) << bits);
    endfunction

    function automatic bar_t random_bar();
        bar_t   b;
        int     kind, bits;
        longint o, c, h, l;
        kind = $urandom_range(0, 99);
        bits = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24) : $urandom_range(2, 10);
        if (kind < 8) begin
            // noise: unrelated prices, often malformed
            b = make_bar($urandom, $urandom, $urandom, $urandom, 1'b0, 2'b00);
        end else if (kind < 12) begin
            b = make_bar($urandom_range(0, 1) ? PX_MAX : 0, $urandom_range(0, 1) ? PX_MAX : 0,
                         $urandom_range(0, 1) ? PX_MAX : 0, $urandom_range(0, 1) ? PX_MAX : 0,
                         1'b0, 2'b00);
        end else begin
            if ($urandom_range(0, 99) < 3) begin
                price_level = $urandom & PX_MAX;
            end
            price_level = clamp_px(price_level + jitter(bits));
            o = clamp_px(price_level + jitter(bits));
            c = clamp_px(price_level + jitter(bits));
            h = clamp_px(((o > c) ? o : c) + $urandom_range(0, 1 << bits));
            l = clamp_px(((o < c) ? o : c) - $urandom_range(0, 1 << bits));
            b = make_bar(o, h, l, c, 1'b0, 2'b00);
        end
        b.complete = ($urandom_range(0, 9) != 0);
        b.pos = $urandom_range(0, 3);
        return b;
    endfunction

    task automatic send_bar(input bar_t b);
        while ($urandom_range(0, 99) < valid_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_bar_open <= b.open_px;
        s_bar_high <= b.high_px;
        s_bar_low <= b.low_px;
        s_bar_close <= b.close_px;
        s_bar_complete <= b.complete;
        s_position_sign <= b.pos;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        expected_signals.push_back(predict_breakout(b));
    endtask

    task automatic send_random_bars(input int count);
        repeat (count) send_bar(random_bar());
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_signals.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            REG_WINDOW_DAYS: cfg_days = data;
            REG_UPPER_GAIN:  cfg_up = data;
            REG_LOWER_GAIN:  cfg_lo = data;
            REG_STOCK_MODE:  cfg_stock = data;
            default: ;
        endcase
    endtask

    // Registers change only with the pipeline empty
    task automatic configure(input int unsigned days, up_gain, lo_gain, stock);
        wait_idle();
        write_reg(REG_WINDOW_DAYS, days);
        write_reg(REG_UPPER_GAIN, up_gain);
        write_reg(REG_LOWER_GAIN, lo_gain);
        write_reg(REG_STOCK_MODE, stock);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_directed_cases();
        valid_gap_pct = 0;
        ready_stall_pct = 0;
        // window below two acts as two: one bar of history
        configure(0, 4096, 4096, 0);
        send_bar(make_bar(1000, 1100, 900, 1050, 1'b1, POS_FLAT));
        send_bar(make_bar(1000, 1150, 990, 1100, 1'b0, POS_FLAT));
        send_bar(make_bar(1000, 1149, 850, 900, 1'b0, POS_FLAT));
        send_bar(make_bar(1000, 1200, 851, 1100, 1'b0, POS_LONG));
        send_bar(make_bar(1000, 1000, 850, 900, 1'b0, POS_LONG));
        send_bar(make_bar(1000, 1150, 950, 1100, 1'b0, POS_SHORT));
        send_bar(make_bar(1000, 1150, 950, 1100, 1'b0, POS_ODD));
        send_bar(make_bar(1000, 1149, 950, 1100, 1'b0, POS_SHORT));
        send_bar(make_bar(0, 0, 0, 0, 1'b0, POS_FLAT));
        send_bar(make_bar(PX_MAX, PX_MAX, PX_MAX, PX_MAX, 1'b0, POS_FLAT));
        // malformed bar in history gives a negative range
        send_bar(make_bar(500, 0, PX_MAX, 1000, 1'b1, POS_FLAT));
        send_bar(make_bar(5000, 4000, 6000, 5000, 1'b0, POS_FLAT));
        send_bar(make_bar(5000, 3000, 6000, 5000, 1'b0, POS_SHORT));
        // full-scale gains drive the upper band into saturation
        configure(0, 65535, 65535, 0);
        send_bar(make_bar(0, PX_MAX, 0, 0, 1'b1, POS_LONG));
        send_bar(make_bar(PX_MAX, PX_MAX, 0, PX_MAX, 1'b0, POS_FLAT));
        send_bar(make_bar(0, 0, 0, 0, 1'b0, POS_FLAT));
        configure(2, 4096, 4096, 1);
        send_bar(make_bar(1000, 1100, 900, 1050, 1'b1, POS_FLAT));
        send_bar(make_bar(1000, 1150, 990, 1100, 1'b0, POS_FLAT));
        send_bar(make_bar(1000, 1000, 850, 900, 1'b0, POS_FLAT));
        send_bar(make_bar(1000, 1150, 950, 1100, 1'b0, POS_SHORT));
        send_bar(make_bar(1000, 1000, 850, 900, 1'b0, POS_LONG));
        send_bar(make_bar(1000, 1150, 950, 1100, 1'b0, POS_ODD));
    endtask

    task automatic test_default_window();
        configure(21, 2048, 2048, 0);
        valid_gap_pct = 0;
        ready_stall_pct = 0;
        send_random_bars(250);
    endtask

    task automatic test_longest_legal_window();
        configure(65, 65535, 0, 0);
        valid_gap_pct = 63;
        ready_stall_pct = 0;
        send_random_bars(250);
    endtask

    task automatic test_clamped_window_stock();
        configure(127, $urandom_range(0, 8191), $urandom_range(0, 8191), 1);
        valid_gap_pct = 0;
        ready_stall_pct = 63;
        send_random_bars(250);
    endtask

    task automatic test_window_of_one();
        configure(1, 2048, 6144, 0);
        valid_gap_pct = 24;
        ready_stall_pct = 24;
        send_random_bars(200);
    endtask

    task automatic test_gain_extremes();
        configure(2, 0, 65535, 0);
        valid_gap_pct = 0;
        ready_stall_pct = 0;
        send_random_bars(150);
    endtask

    // Hold the result channel long enough that the block stalls its input
    task automatic test_backpressure();
        configure(5, 2048, 2048, 0);
        valid_gap_pct = 0;
        ready_stall_pct = 0;
        hold_left = 500;
        send_random_bars(60);
    endtask

    task automatic test_random_settings();
        int phase;
        for (phase = 0; phase < 8; phase++) begin
            configure($urandom_range(0, 127), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 1));
            case (phase % 4)
                0: begin valid_gap_pct = 0;  ready_stall_pct = 0;  end
                1: begin valid_gap_pct = 63; ready_stall_pct = 0;  end
                2: begin valid_gap_pct = 0;  ready_stall_pct = 63; end
                default: begin valid_gap_pct = 24; ready_stall_pct = 24; end
            endcase
            send_random_bars(60);
        end
    endtask

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= ready_stall_pct);
        end
    end

    always @(posedge aclk) begin
        breakout_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_signals.size() == 0) begin
                $display("%0t: result with nothing expected: signal %0d", $time, m_signal);
                errors++;
            end else begin
                want = expected_signals.pop_front();
                if (m_signal !== want.sig) begin
                    $display("%0t: signal expected %0d got %0d", $time, want.sig, m_signal);
                    errors++;
                end
                if (m_target_position !== want.target) begin
                    $display("%0t: target_position expected %0d got %0d", $time,
                             want.target, m_target_position);
                    errors++;
                end
                if (m_upper_band !== want.upper) begin
                    $display("%0t: upper_band expected %0d got %0d", $time,
                             want.upper, m_upper_band);
                    errors++;
                end
                if (m_lower_band !== want.lower) begin
                    $display("%0t: lower_band expected %0d got %0d", $time,
                             want.lower, m_lower_band);
                    errors++;
                end
                if (m_window_ready !== want.ready) begin
                    $display("%0t: window_ready expected %0d got %0d", $time,
                             want.ready, m_window_ready);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_default_window();
        test_longest_legal_window();
        test_clamped_window_stock();
        test_window_of_one();
        test_gain_extremes();
        test_backpressure();
        test_random_settings();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
